// File: rtl/core/vad_pkg.sv
// Shared types, constants and the normalize step for the vertex attribute dequantizer.
package vad_pkg;

    localparam int NUM_RANGES = 5;
    localparam int CFG_W      = 64;
    localparam int NORM_STEPS = 15;
    localparam int NORM_LAT   = NORM_STEPS + 2;
    localparam int DQ_LAT     = 8;
    localparam int DQ_DLY     = NORM_LAT - DQ_LAT;

    typedef logic [2:0] cfg_idx_t;

    localparam cfg_idx_t IDX_POS_X = 3'd0;
    localparam cfg_idx_t IDX_POS_Y = 3'd1;
    localparam cfg_idx_t IDX_POS_Z = 3'd2;
    localparam cfg_idx_t IDX_TEX_U = 3'd3;
    localparam cfg_idx_t IDX_TEX_V = 3'd4;

    typedef struct packed {
        logic [15:0] quant_x;
        logic [15:0] quant_y;
        logic [15:0] quant_z;
        logic [15:0] quant_u;
        logic [15:0] quant_v;
        logic [31:0] normal_packed;
    } vad_req_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
    } vad_result_t;

    typedef struct packed {
        logic [50:0]        e;
        logic signed [39:0] f;
        logic [14:0]        r;
    } nstep_t;

    // e = (2r-1)^2 * s, f = (2r-1) * s; try bit k of r against rhs
    function automatic nstep_t nstep(nstep_t cur, logic [21:0] s, logic [49:0] rhs,
                                     int k);
        logic signed [57:0] cand;
        nstep_t             nxt;
        cand = 58'(cur.e) + (58'(cur.f) <<< (k + 2)) + (58'(s) << (2 * k + 2));
        nxt  = cur;
        if (!cand[57] && (cand[56:0] <= 57'(rhs)))
        begin
            nxt.e = cand[50:0];
            nxt.f = cur.f + (40'(s) << (k + 1));
            nxt.r = cur.r | (15'(1) << k);
        end
        return nxt;
    endfunction

endpackage

// File: rtl/core/vad_dequant.sv
// One dequantize lane: lo + round((hi - lo) * q / 65535), pipelined and aligned.
module vad_dequant (
    input  logic               clk,
    input  logic [63:0]        range,
    input  logic [15:0]        code,
    output logic signed [31:0] value
);
    import vad_pkg::*;

    logic signed [32:0] diff_reg;
    logic [15:0]        code_reg;
    logic [31:0]        lo_reg [7];
    logic signed [49:0] prod_reg;
    logic               neg_reg [5];
    logic [49:0]        n_reg;
    logic [33:0]        a_reg;
    logic [34:0]        c_reg;
    logic [34:0]        acc5_reg;
    logic [19:0]        c5_reg;
    logic [34:0]        acc6_reg;
    logic [16:0]        c6_reg;
    logic [34:0]        q_reg;
    logic [34:0]        r_reg;
    logic [31:0]        dly_reg [DQ_DLY];

    always_ff @(posedge clk)
    begin
        diff_reg <= $signed({range[63], range[63:32]}) - $signed({range[31], range[31:0]});
        code_reg <= code;
        lo_reg[0] <= range[31:0];
        for (int i = 1; i < 7; i++)
        begin
            lo_reg[i] <= lo_reg[i-1];
        end

        prod_reg <= diff_reg * $signed({1'b0, code_reg});

        neg_reg[0] <= prod_reg[49];
        for (int i = 1; i < 5; i++)
        begin
            neg_reg[i] <= neg_reg[i-1];
        end
        n_reg <= (prod_reg[49] ? 50'(-prod_reg) : 50'(prod_reg)) + 50'(32767);

        a_reg <= n_reg[49:16];
        c_reg <= 35'(n_reg[49:16]) + 35'(n_reg[15:0]);

        acc5_reg <= 35'(a_reg) + 35'(c_reg[34:16]);
        c5_reg   <= 20'(c_reg[34:16]) + 20'(c_reg[15:0]);

        acc6_reg <= acc5_reg + 35'(c5_reg[19:16]);
        c6_reg   <= 17'(c5_reg[19:16]) + 17'(c5_reg[15:0]);

        q_reg <= acc6_reg + 35'(c6_reg >= 17'(65535));

        r_reg <= neg_reg[4] ? 35'($signed(lo_reg[6])) - q_reg
                            : 35'($signed(lo_reg[6])) + q_reg;

        dly_reg[0] <= r_reg[31:0];
        for (int i = 1; i < DQ_DLY; i++)
        begin
            dly_reg[i] <= dly_reg[i-1];
        end
    end

    assign value = $signed(dly_reg[DQ_DLY-1]);

endmodule

// File: rtl/core/vad_normalize.sv
// Normal decode: unpack 10:10:10, then bit-serial normalize one result bit per stage.
module vad_normalize (
    input  logic              clk,
    input  logic [31:0]       packed_in,
    output logic [2:0][15:0]  norm
);
    import vad_pkg::*;

    logic signed [10:0] a_val [3];
    logic [9:0]         mag [3];
    logic [19:0]        sq1_reg [3];
    logic               neg1_reg [3];
    logic [21:0]        s_reg [NORM_STEPS];
    logic [19:0]        sq_reg [NORM_STEPS][3];
    logic               neg_reg [NORM_STEPS+1][3];
    nstep_t             st_reg [NORM_STEPS+1][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_val[i] = $signed({packed_in[10*i +: 10], 1'b0}) - 11'sd1023;
            mag[i]   = a_val[i][10] ? 10'(-a_val[i]) : a_val[i][9:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq1_reg[i]  <= mag[i] * mag[i];
            neg1_reg[i] <= a_val[i][10];
        end

        s_reg[0] <= 22'(sq1_reg[0]) + 22'(sq1_reg[1]) + 22'(sq1_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            sq_reg[0][i]   <= sq1_reg[i];
            neg_reg[0][i]  <= neg1_reg[i];
            st_reg[0][i].e <= 51'(22'(sq1_reg[0]) + 22'(sq1_reg[1]) + 22'(sq1_reg[2]));
            st_reg[0][i].f <= -40'(22'(sq1_reg[0]) + 22'(sq1_reg[1]) + 22'(sq1_reg[2]));
            st_reg[0][i].r <= '0;
        end

        for (int j = 1; j <= NORM_STEPS; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                st_reg[j][i]  <= nstep(st_reg[j-1][i], s_reg[j-1],
                                       50'(sq_reg[j-1][i]) << 30, NORM_STEPS - j);
                neg_reg[j][i] <= neg_reg[j-1][i];
            end
            if (j < NORM_STEPS)
            begin
                s_reg[j]  <= s_reg[j-1];
                sq_reg[j] <= sq_reg[j-1];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            norm[i] = neg_reg[NORM_STEPS][i] ? 16'(-{1'b0, st_reg[NORM_STEPS][i].r})
                                             : 16'(st_reg[NORM_STEPS][i].r);
        end
    end

endmodule

// File: rtl/core/vertex_attribute_dequantizer.sv
// Top level of the vertex attribute dequantizer.
// Throughput: one request per cycle; busy is always low.
// Depth set by the 15-stage bit-serial normal normalize chain plus unpack and output stages.
// Reset clears the five range registers and the valid pipeline; no request in flight survives.
// The receiver cannot stall; each result is shown for one cycle with done.
module vertex_attribute_dequantizer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  vad_pkg::vad_req_t    req,
    input  logic                 cfg_we,
    input  vad_pkg::cfg_idx_t    cfg_index,
    input  logic [63:0]          cfg_data,
    output logic                 done,
    output vad_pkg::vad_result_t result
);
    import vad_pkg::*;

    logic [CFG_W-1:0]   range_reg [NUM_RANGES];
    logic [NORM_LAT-1:0] vld_reg;
    logic               done_reg;
    vad_result_t        result_reg;
    vad_result_t        result_next;
    logic signed [31:0] dq_val [NUM_RANGES];
    logic [15:0]        dq_code [NUM_RANGES];
    logic [2:0][15:0]   norm;

    assign busy = 1'b0;

    assign dq_code[IDX_POS_X] = req.quant_x;
    assign dq_code[IDX_POS_Y] = req.quant_y;
    assign dq_code[IDX_POS_Z] = req.quant_z;
    assign dq_code[IDX_TEX_U] = req.quant_u;
    assign dq_code[IDX_TEX_V] = req.quant_v;

    for (genvar g = 0; g < NUM_RANGES; g++)
    begin : g_lane
        vad_dequant u_dq (
            .clk   (clk),
            .range (range_reg[g]),
            .code  (dq_code[g]),
            .value (dq_val[g])
        );
    end

    vad_normalize u_norm (
        .clk       (clk),
        .packed_in (req.normal_packed),
        .norm      (norm)
    );

    always_comb
    begin
        result_next.pos_x  = dq_val[IDX_POS_X];
        result_next.pos_y  = dq_val[IDX_POS_Y];
        result_next.pos_z  = dq_val[IDX_POS_Z];
        result_next.tex_u  = dq_val[IDX_TEX_U];
        result_next.tex_v  = dq_val[IDX_TEX_V];
        result_next.norm_x = $signed(norm[0]);
        result_next.norm_y = $signed(norm[1]);
        result_next.norm_z = $signed(norm[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_RANGES; i++)
            begin
                range_reg[i] <= '0;
            end
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index <= IDX_TEX_V))
            begin
                range_reg[cfg_index] <= cfg_data;
            end
            vld_reg  <= {vld_reg[NORM_LAT-2:0], start & ~busy};
            done_reg <= vld_reg[NORM_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the vertex attribute dequantizer: random and corner vertices.
`timescale 1ns / 100ps

module testbench;

    import vad_pkg::*;

    localparam int LATENCY   = 18;
    localparam int WDOG_MAX  = 2000;
    localparam int RAND_ITEMS = 1350;

    localparam cfg_idx_t IDX_UNUSED = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    vad_req_t    req;
    logic        cfg_we;
    cfg_idx_t    cfg_index;
    logic [63:0] cfg_data;
    logic        done;
    vad_result_t result;

    vertex_attribute_dequantizer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    logic [63:0] range_regs [NUM_RANGES];
    vad_req_t    pending_reqs [$];
    vad_result_t expected_vertices [$];
    int          gap_left;
    int          error_count;
    int          idle_cycles;
    bit          stim_done;
    bit          hold_req;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic add_req(vad_req_t item);
        pending_reqs = {pending_reqs, item};
    endtask

    function automatic logic [31:0] dequant_axis(logic [63:0] rng, logic [15:0] code);
        longint lo;
        longint hi;
        longint prod;
        longint mag;
        longint q;
        lo   = longint'($signed(rng[31:0]));
        hi   = longint'($signed(rng[63:32]));
        prod = (hi - lo) * longint'({48'd0, code});
        mag  = (prod < 0) ? -prod : prod;
        q    = (2 * mag + 65535) / (2 * 65535);
        return (prod < 0) ? 32'(lo - q) : 32'(lo + q);
    endfunction

    function automatic logic [15:0] unit_comp(longint a, longint s);
        longint mag;
        longint rhs;
        longint lo;
        longint hi;
        longint mid;
        longint d;
        mag = (a < 0) ? -a : a;
        rhs = (2 * 16384 * mag) * (2 * 16384 * mag);
        lo  = 0;
        hi  = 16384;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            d   = 2 * mid - 1;
            if (d * d * s <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return (a < 0) ? 16'(-lo) : 16'(lo);
    endfunction

    function automatic vad_result_t decode_vertex(vad_req_t r);
        vad_result_t v;
        longint      a [3];
        longint      s;
        s = 0;
        v.pos_x = dequant_axis(range_regs[IDX_POS_X], r.quant_x);
        v.pos_y = dequant_axis(range_regs[IDX_POS_Y], r.quant_y);
        v.pos_z = dequant_axis(range_regs[IDX_POS_Z], r.quant_z);
        v.tex_u = dequant_axis(range_regs[IDX_TEX_U], r.quant_u);
        v.tex_v = dequant_axis(range_regs[IDX_TEX_V], r.quant_v);
        for (int i = 0; i < 3; i++)
        begin
            a[i] = 2 * longint'(r.normal_packed[10*i +: 10]) - 1023;
            s += a[i] * a[i];
        end
        v.norm_x = unit_comp(a[0], s);
        v.norm_y = unit_comp(a[1], s);
        v.norm_z = unit_comp(a[2], s);
        return v;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
        error_count++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            req      <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_vertices = {expected_vertices, decode_vertex(req)};
            end
            if (start && busy)
            begin
                // hold
            end
            else if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_reqs.size() > 0 && !hold_req)
            begin
                start    <= 1'b1;
                req      <= pending_reqs.pop_front();
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_vertices.size() == 0)
            begin
                report_mismatch("unexpected result", 0, 0);
            end
            else
            begin
                vad_result_t w;
                w = expected_vertices.pop_front();
                if (result.pos_x !== w.pos_x) report_mismatch("pos_x", result.pos_x, w.pos_x);
                if (result.pos_y !== w.pos_y) report_mismatch("pos_y", result.pos_y, w.pos_y);
                if (result.pos_z !== w.pos_z) report_mismatch("pos_z", result.pos_z, w.pos_z);
                if (result.tex_u !== w.tex_u) report_mismatch("tex_u", result.tex_u, w.tex_u);
                if (result.tex_v !== w.tex_v) report_mismatch("tex_v", result.tex_v, w.tex_v);
                if (result.norm_x !== w.norm_x)
                    report_mismatch("norm_x", result.norm_x, w.norm_x);
                if (result.norm_y !== w.norm_y)
                    report_mismatch("norm_y", result.norm_y, w.norm_y);
                if (result.norm_z !== w.norm_z)
                    report_mismatch("norm_z", result.norm_z, w.norm_z);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (pending_reqs.size() == 0 && stim_done))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic vad_req_t random_vertex();
        vad_req_t r;
        r.quant_x       = 16'($urandom);
        r.quant_y       = 16'($urandom);
        r.quant_z       = 16'($urandom);
        r.quant_u       = 16'($urandom);
        r.quant_v       = 16'($urandom);
        r.normal_packed = $urandom;
        case ($urandom_range(0, 5))
            0: r.quant_x = '1;
            1: r.quant_y = '0;
            2: r.normal_packed[9:0] = '1;
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] random_range();
        case ($urandom_range(0, 4))
            0: return {32'h7fff_ffff, 32'h8000_0000};
            1: return {32'h8000_0000, 32'h7fff_ffff};
            2: return {$urandom, $urandom};
            default: return {32'($signed($urandom_range(0, 2000000)) - 1000000),
                             32'($signed($urandom_range(0, 2000000)) - 1000000)};
        endcase
    endfunction

    task automatic write_range(cfg_idx_t idx, logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx <= IDX_TEX_V)
            range_regs[idx] = val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || start || expected_vertices.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    initial
    begin
        vad_req_t r;
        error_count = 0;
        stim_done   = 1'b0;
        hold_req    = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = IDX_POS_X;
        cfg_data    = '0;
        for (int i = 0; i < NUM_RANGES; i++)
            range_regs[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // first request uses the ranges still at their reset value
        add_req({16'hffff, 16'h1234, 16'h0, 16'hffff, 16'h8000, 32'hffff_ffff});
        drain();
        write_range(IDX_POS_X, {32'h7fff_ffff, 32'h8000_0000});
        write_range(IDX_POS_Y, {32'h8000_0000, 32'h7fff_ffff});
        write_range(IDX_POS_Z, {32'h0001_0000, 32'hffff_0000});
        write_range(IDX_TEX_U, {32'h0000_0000, 32'h0001_0000});
        write_range(IDX_TEX_V, {32'h1234_5678, 32'h1234_5678});
        for (int i = 0; i < 3; i++)
        begin
            r = '0;
            r.quant_x = (i == 0) ? 16'h0 : (i == 1) ? 16'hffff : 16'h8000;
            r.quant_y = r.quant_x;
            r.quant_z = r.quant_x;
            r.quant_u = r.quant_x;
            r.quant_v = r.quant_x;
            add_req(r);
        end
        for (int i = 0; i < 32; i++)
        begin
            r = '0;
            r.normal_packed = 32'h1 << i;
            add_req(r);
        end
        r.normal_packed = 32'h3fff_ffff;
        add_req(r);
        r.normal_packed = {2'b10, 10'd511, 10'd512, 10'd0};
        add_req(r);
        drain();
        for (int phase = 0; phase < 6; phase++)
        begin
            for (int k = 0; k < NUM_RANGES; k++)
                write_range(cfg_idx_t'(k), random_range());
            write_range(IDX_UNUSED, {$urandom, $urandom});
            for (int n = 0; n < RAND_ITEMS / 6; n++)
                add_req(random_vertex());
            if (phase == 2)
            begin
                while (pending_reqs.size() > 100)
                    @(posedge clk);
                hold_req <= 1'b1;
                @(posedge clk);
                while (expected_vertices.size() > 0 || start)
                    @(posedge clk);
                hold_req <= 1'b0;
            end
            drain();
        end
        stim_done = 1'b1;
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
